FILE: sv/srfr_pkg.sv
// Shared types and constants for the sample ring with frame read and RMS level.
package srfr_pkg;

	localparam int SMP_W   = 16;
	localparam int AVAIL_W = 12;
	localparam int LEVEL_W = 16;
	localparam int ALU_W   = 32;
	localparam int QUO_W   = 31;
	localparam int SQ_W    = 32;

	localparam logic [AVAIL_W-1:0] AVAIL_MAX = '1;
	localparam logic [ALU_W-1:0]   SQRT_TOP  = 32'h4000_0000;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [1:0] KIND_STORED = 2'd0;
	localparam logic [1:0] KIND_DROP   = 2'd1;
	localparam logic [1:0] KIND_FRAME  = 2'd2;
	localparam logic [1:0] KIND_NA     = 2'd3;

	typedef struct packed {
		logic                    opcode;
		logic signed [SMP_W-1:0] sample_in;
		logic                    block_end;
	} in_item_t;

	typedef struct packed {
		logic [1:0]              result_kind;
		logic signed [SMP_W-1:0] sample_out;
		logic                    frame_last;
		logic [AVAIL_W-1:0]      available_count;
		logic [LEVEL_W-1:0]      rms_level;
	} out_item_t;

	typedef struct packed {
		logic             go;
		logic [SMP_W-1:0] sample;
		logic             block_end;
	} lvl_req_t;

	typedef struct packed {
		logic               busy;
		logic [LEVEL_W-1:0] level;
	} lvl_stat_t;

endpackage

FILE: sv/sample_ring_with_frame_read_and_rms.sv
// Sample ring with frame read and integer RMS level of the last capture block.
//
// Request channel (req_valid, req_stall, req_data): a push stores one sample
// while capture_enable is set, otherwise it is dropped; a read takes one frame
// of FRAME_LENGTH samples, oldest first. Response channel (rsp_valid,
// rsp_stall, rsp_data): one response per push, FRAME_LENGTH responses per
// frame read, or a single not-available response when too few samples wait.
// Every response carries the waiting sample count and the current RMS level.
// One transaction is handled at a time; req_stall is high while it runs.
// A push waits until the level engine is idle again; when it ends a block
// the shared subtract-compare unit runs the restoring divide one bit a
// cycle and then the square root one result bit a cycle. A frame read
// passes each sample through the ring read port, then the response
// register, and reads the next sample only once the last is loaded. The
// response register frees the request side while a response waits;
// rsp_stall holds the response and pauses the sequencer.
// Reset clears pointers, count, block sums, level and capture_enable; ring
// contents stay undefined and need no clearing pass.
module sample_ring_with_frame_read_and_rms #(
	parameter int BUFFER_DEPTH = 4096,
	parameter int FRAME_LENGTH = 32,
	parameter int BLOCK_MAX    = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_data,
	input  logic                req_valid,
	output logic                req_stall,
	input  srfr_pkg::in_item_t  req_data,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output srfr_pkg::out_item_t rsp_data
);

	localparam int PTR_W = $clog2(BUFFER_DEPTH);
	localparam int CW    = (PTR_W > srfr_pkg::AVAIL_W) ? PTR_W : srfr_pkg::AVAIL_W;
	localparam int FL_W  = $clog2(FRAME_LENGTH + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PUSH  = 3'd1;
	localparam logic [2:0] S_EMIT  = 3'd2;
	localparam logic [2:0] S_RD    = 3'd3;
	localparam logic [2:0] S_FWAIT = 3'd4;

	logic [2:0]        state_q;
	logic              cfg_en_q;
	logic [PTR_W-1:0]  wp_q;
	logic [PTR_W-1:0]  rp_q;
	logic [PTR_W-1:0]  count_q;
	logic [FL_W-1:0]   fcnt_q;
	logic [1:0]        pend_kind_q;
	logic              rsp_valid_q;
	srfr_pkg::out_item_t rsp_data_q;

	logic              accept;
	logic              out_free;
	logic              load;
	srfr_pkg::out_item_t rsp_nxt;
	logic [PTR_W-1:0]  wp_inc;
	logic [PTR_W-1:0]  rp_inc;
	logic [CW-1:0]     count_ext;
	logic [srfr_pkg::AVAIL_W-1:0] avail;
	logic              ring_we;
	logic              ring_re;
	logic [srfr_pkg::SMP_W-1:0] ring_rdata;
	srfr_pkg::lvl_req_t  lvl_req;
	srfr_pkg::lvl_stat_t lvl_stat;

	srfr_ring #(
		.DEPTH (BUFFER_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (wp_q),
		.wdata (req_data.sample_in),
		.re    (ring_re),
		.raddr (rp_q),
		.rdata (ring_rdata)
	);

	srfr_level #(
		.BLOCK_MAX (BLOCK_MAX)
	) u_level (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lvl_req),
		.stat   (lvl_stat)
	);

	always_comb begin
		req_stall = (state_q != S_IDLE);
		accept    = req_valid && !req_stall;
		out_free  = !rsp_valid_q || !rsp_stall;
		wp_inc    = (wp_q == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
		rp_inc    = (rp_q == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
		count_ext = CW'(count_q);
		avail     = (count_ext > CW'(srfr_pkg::AVAIL_MAX)) ? srfr_pkg::AVAIL_MAX
		                                                   : count_ext[srfr_pkg::AVAIL_W-1:0];
		ring_we   = accept && (req_data.opcode == srfr_pkg::OP_PUSH) && cfg_en_q;
		ring_re   = (state_q == S_RD);

		lvl_req.go        = ring_we;
		lvl_req.sample    = req_data.sample_in;
		lvl_req.block_end = req_data.block_end;

		rsp_nxt.result_kind     = pend_kind_q;
		rsp_nxt.sample_out      = '0;
		rsp_nxt.frame_last      = 1'b0;
		rsp_nxt.available_count = avail;
		rsp_nxt.rms_level       = lvl_stat.level;
		load                    = 1'b0;
		unique case (state_q)
			S_PUSH: begin
				rsp_nxt.result_kind = srfr_pkg::KIND_STORED;
				load                = out_free && !lvl_stat.busy;
			end
			S_EMIT: begin
				load = out_free;
			end
			S_FWAIT: begin
				rsp_nxt.result_kind = srfr_pkg::KIND_FRAME;
				rsp_nxt.sample_out  = ring_rdata;
				rsp_nxt.frame_last  = (fcnt_q == FL_W'(1));
				load                = out_free;
			end
			default: begin
				load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cfg_en_q    <= 1'b0;
			wp_q        <= '0;
			rp_q        <= '0;
			count_q     <= '0;
			fcnt_q      <= '0;
			pend_kind_q <= srfr_pkg::KIND_STORED;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_en_q <= cfg_data;
			end
			if (load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req_data.opcode == srfr_pkg::OP_PUSH) begin
							if (cfg_en_q) begin
								wp_q <= wp_inc;
								if (count_q == PTR_W'(BUFFER_DEPTH - 1)) begin
									rp_q <= rp_inc;
								end else begin
									count_q <= count_q + PTR_W'(1);
								end
								state_q <= S_PUSH;
							end else begin
								pend_kind_q <= srfr_pkg::KIND_DROP;
								state_q     <= S_EMIT;
							end
						end else if (count_ext < CW'(FRAME_LENGTH)) begin
							pend_kind_q <= srfr_pkg::KIND_NA;
							state_q     <= S_EMIT;
						end else begin
							count_q <= count_q - PTR_W'(FRAME_LENGTH);
							fcnt_q  <= FL_W'(FRAME_LENGTH);
							state_q <= S_RD;
						end
					end
				end
				S_PUSH, S_EMIT: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				S_RD: begin
					rp_q    <= rp_inc;
					state_q <= S_FWAIT;
				end
				S_FWAIT: begin
					if (load) begin
						fcnt_q  <= fcnt_q - FL_W'(1);
						state_q <= (fcnt_q == FL_W'(1)) ? S_IDLE : S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_data_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

endmodule

FILE: sv/srfr_ring.sv
// Sample ring storage: one write port, one registered read port.
module srfr_ring #(
	parameter int DEPTH = 4096
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(DEPTH)-1:0]      waddr,
	input  logic [srfr_pkg::SMP_W-1:0]    wdata,
	input  logic                          re,
	input  logic [$clog2(DEPTH)-1:0]      raddr,
	output logic [srfr_pkg::SMP_W-1:0]    rdata
);

	logic [srfr_pkg::SMP_W-1:0] mem_q [DEPTH];
	logic [srfr_pkg::SMP_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/srfr_alu.sv
// Shared subtract-and-compare unit: a minus (b0 + b1) and its sign.
module srfr_alu (
	input  logic [srfr_pkg::ALU_W-1:0] a,
	input  logic [srfr_pkg::ALU_W-1:0] b0,
	input  logic [srfr_pkg::ALU_W-1:0] b1,
	output logic [srfr_pkg::ALU_W-1:0] diff,
	output logic                       ge
);

	logic [srfr_pkg::ALU_W:0] sub_sum;

	always_comb begin
		sub_sum = {1'b0, b0} + {1'b0, b1};
		ge      = {1'b0, a} >= sub_sum;
		diff    = a - sub_sum[srfr_pkg::ALU_W-1:0];
	end

endmodule

FILE: sv/srfr_level.sv
// Block level engine: square, accumulate, divide by count and integer square root.
module srfr_level #(
	parameter int BLOCK_MAX = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  srfr_pkg::lvl_req_t req,
	output srfr_pkg::lvl_stat_t stat
);

	localparam int CNT_W  = $clog2(BLOCK_MAX + 1);
	localparam int SUM_W  = CNT_W + 30;
	localparam int STEP_W = $clog2(SUM_W);

	localparam logic [2:0] L_IDLE = 3'd0;
	localparam logic [2:0] L_SQ   = 3'd1;
	localparam logic [2:0] L_ACC  = 3'd2;
	localparam logic [2:0] L_DIV  = 3'd3;
	localparam logic [2:0] L_SQRT = 3'd4;

	logic [2:0]                    state_q;
	logic [SUM_W-1:0]              sum_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [srfr_pkg::LEVEL_W-1:0]  level_q;

	logic [srfr_pkg::SMP_W-1:0]    mag_q;
	logic                          bend_q;
	logic [srfr_pkg::SQ_W-1:0]     prod_q;
	logic [SUM_W-1:0]              dividend_q;
	logic [CNT_W-1:0]              divisor_q;
	logic [CNT_W-1:0]              rem_q;
	logic [srfr_pkg::QUO_W-1:0]    quo_q;
	logic [STEP_W-1:0]             step_q;
	logic [srfr_pkg::QUO_W-1:0]    v_q;
	logic [srfr_pkg::ALU_W-1:0]    res_q;
	logic [srfr_pkg::ALU_W-1:0]    bit_q;

	logic [srfr_pkg::SMP_W-1:0]    mag;
	logic [SUM_W-1:0]              sum_new;
	logic [CNT_W-1:0]              cnt_new;
	logic                          blk_done;
	logic [CNT_W:0]                shifted;
	logic [srfr_pkg::QUO_W-1:0]    quo_nxt;
	logic [srfr_pkg::ALU_W-1:0]    res_nxt;
	logic [srfr_pkg::ALU_W-1:0]    alu_a;
	logic [srfr_pkg::ALU_W-1:0]    alu_b0;
	logic [srfr_pkg::ALU_W-1:0]    alu_b1;
	logic [srfr_pkg::ALU_W-1:0]    alu_diff;
	logic                          alu_ge;

	srfr_alu u_alu (
		.a    (alu_a),
		.b0   (alu_b0),
		.b1   (alu_b1),
		.diff (alu_diff),
		.ge   (alu_ge)
	);

	always_comb begin
		mag      = req.sample[srfr_pkg::SMP_W-1] ? (~req.sample + 16'd1) : req.sample;
		sum_new  = sum_q + SUM_W'(prod_q);
		cnt_new  = cnt_q + CNT_W'(1);
		blk_done = bend_q || (cnt_new >= CNT_W'(BLOCK_MAX));
		shifted  = {rem_q, dividend_q[SUM_W-1]};
		quo_nxt  = {quo_q[srfr_pkg::QUO_W-2:0], alu_ge};
		res_nxt  = alu_ge ? ((res_q >> 1) + bit_q) : (res_q >> 1);
		if (state_q == L_DIV) begin
			alu_a  = srfr_pkg::ALU_W'(shifted);
			alu_b0 = srfr_pkg::ALU_W'(divisor_q);
			alu_b1 = '0;
		end else begin
			alu_a  = srfr_pkg::ALU_W'(v_q);
			alu_b0 = res_q;
			alu_b1 = bit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			sum_q   <= '0;
			cnt_q   <= '0;
			level_q <= '0;
		end else begin
			unique case (state_q)
				L_IDLE: begin
					if (req.go) begin
						state_q <= L_SQ;
					end
				end
				L_SQ: begin
					state_q <= L_ACC;
				end
				L_ACC: begin
					if (blk_done) begin
						sum_q   <= '0;
						cnt_q   <= '0;
						state_q <= L_DIV;
					end else begin
						sum_q   <= sum_new;
						cnt_q   <= cnt_new;
						state_q <= L_IDLE;
					end
				end
				L_DIV: begin
					if (step_q == '0) begin
						state_q <= L_SQRT;
					end
				end
				L_SQRT: begin
					if (bit_q[0]) begin
						level_q <= res_nxt[srfr_pkg::LEVEL_W-1:0];
						state_q <= L_IDLE;
					end
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == L_IDLE && req.go) begin
			mag_q  <= mag;
			bend_q <= req.block_end;
		end
		if (state_q == L_SQ) begin
			prod_q <= mag_q * mag_q;
		end
		if (state_q == L_ACC) begin
			dividend_q <= sum_new;
			divisor_q  <= cnt_new;
			rem_q      <= '0;
			quo_q      <= '0;
			step_q     <= STEP_W'(SUM_W - 1);
		end
		if (state_q == L_DIV) begin
			rem_q      <= alu_ge ? alu_diff[CNT_W-1:0] : shifted[CNT_W-1:0];
			dividend_q <= dividend_q << 1;
			quo_q      <= quo_nxt;
			step_q     <= step_q - STEP_W'(1);
			v_q        <= quo_nxt;
			res_q      <= '0;
			bit_q      <= srfr_pkg::SQRT_TOP;
		end
		if (state_q == L_SQRT) begin
			if (alu_ge) begin
				v_q <= alu_diff[srfr_pkg::QUO_W-1:0];
			end
			res_q <= res_nxt;
			bit_q <= bit_q >> 2;
		end
	end

	assign stat.busy  = (state_q != L_IDLE);
	assign stat.level = level_q;

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for the sample ring with frame read and RMS level.
module testbench;

	localparam int RING_DEPTH  = 4096;
	localparam int FRAME_LEN   = 32;
	localparam int BLOCK_LIMIT = 1024;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE      = 120;
	localparam int HOLD_LEN    = 600;
	localparam int FILL_PUSHES = 40;
	localparam int N_ROWS      = 21;

	typedef enum logic [1:0] {ROW_PUSH, ROW_READ, ROW_CFG} row_act_t;

	typedef struct packed {
		row_act_t                          act;
		logic signed [srfr_pkg::SMP_W-1:0] smp;
		logic                              flag;
		logic                              typed;
		logic [1:0]                        kind;
		logic [srfr_pkg::AVAIL_W-1:0]      avail;
		logic [srfr_pkg::LEVEL_W-1:0]      lvl;
	} dir_row_t;

	dir_row_t dir_rows [N_ROWS] = '{
		'{ROW_READ, 16'sd0,     1'b0, 1'b1, srfr_pkg::KIND_NA,     12'd0,  16'd0},
		'{ROW_PUSH, 16'sd1234,  1'b0, 1'b1, srfr_pkg::KIND_DROP,   12'd0,  16'd0},
		'{ROW_PUSH, 16'sh8000,  1'b1, 1'b1, srfr_pkg::KIND_DROP,   12'd0,  16'd0},
		'{ROW_CFG,  16'sd0,     1'b1, 1'b0, srfr_pkg::KIND_STORED, 12'd0,  16'd0},
		'{ROW_PUSH, 16'sh8000,  1'b1, 1'b1, srfr_pkg::KIND_STORED, 12'd1,  16'd32768},
		'{ROW_PUSH, 16'sh7FFF,  1'b1, 1'b1, srfr_pkg::KIND_STORED, 12'd2,  16'd32767},
		'{ROW_PUSH, 16'sd0,     1'b1, 1'b1, srfr_pkg::KIND_STORED, 12'd3,  16'd0},
		'{ROW_PUSH, 16'sd3,     1'b0, 1'b1, srfr_pkg::KIND_STORED, 12'd4,  16'd0},
		'{ROW_PUSH, -16'sd4,    1'b1, 1'b1, srfr_pkg::KIND_STORED, 12'd5,  16'd3},
		'{ROW_READ, 16'sd0,     1'b0, 1'b1, srfr_pkg::KIND_NA,     12'd5,  16'd3},
		'{ROW_PUSH, 16'sh5555,  1'b0, 1'b0, srfr_pkg::KIND_STORED, 12'd0,  16'd0},
		'{ROW_PUSH, 16'shAAAA,  1'b1, 1'b0, srfr_pkg::KIND_STORED, 12'd0,  16'd0},
		'{ROW_PUSH, -16'sd1,    1'b1, 1'b1, srfr_pkg::KIND_STORED, 12'd8,  16'd1},
		'{ROW_PUSH, 16'sd1,     1'b0, 1'b0, srfr_pkg::KIND_STORED, 12'd0,  16'd0},
		'{ROW_PUSH, 16'sh7FFF,  1'b0, 1'b0, srfr_pkg::KIND_STORED, 12'd0,  16'd0},
		'{ROW_PUSH, 16'sh8000,  1'b1, 1'b0, srfr_pkg::KIND_STORED, 12'd0,  16'd0},
		'{ROW_READ, 16'shFFFF,  1'b1, 1'b0, srfr_pkg::KIND_NA,     12'd0,  16'd0},
		'{ROW_CFG,  16'sd0,     1'b0, 1'b0, srfr_pkg::KIND_STORED, 12'd0,  16'd0},
		'{ROW_PUSH, 16'sd100,   1'b1, 1'b0, srfr_pkg::KIND_DROP,   12'd0,  16'd0},
		'{ROW_READ, 16'sd0,     1'b0, 1'b0, srfr_pkg::KIND_NA,     12'd0,  16'd0},
		'{ROW_CFG,  16'sd0,     1'b1, 1'b0, srfr_pkg::KIND_STORED, 12'd0,  16'd0}
	};

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic                cfg_data  = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_stall;
	srfr_pkg::in_item_t  req_data  = '0;
	logic                rsp_valid;
	logic                rsp_stall = 1'b0;
	srfr_pkg::out_item_t rsp_data;

	logic signed [srfr_pkg::SMP_W-1:0] ring_mem [RING_DEPTH];
	logic [srfr_pkg::AVAIL_W-1:0]      wr_ptr    = '0;
	logic [srfr_pkg::AVAIL_W-1:0]      rd_ptr    = '0;
	longint unsigned                   sq_acc    = 0;
	longint unsigned                   blk_cnt   = 0;
	logic [srfr_pkg::LEVEL_W-1:0]      level_now = '0;
	logic                              capture_on = 1'b0;

	srfr_pkg::out_item_t pending_results [$];
	int          err_count      = 0;
	int          sink_stall_pct = 0;
	int          hold_asked     = 0;
	int          hold_done      = 0;
	int          hold_left      = 0;
	int unsigned cycle_count    = 0;

	sample_ring_with_frame_read_and_rms #(
		.BUFFER_DEPTH(RING_DEPTH),
		.FRAME_LENGTH(FRAME_LEN),
		.BLOCK_MAX(BLOCK_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data(rsp_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [srfr_pkg::AVAIL_W-1:0] ring_fill();
		return wr_ptr - rd_ptr;
	endfunction

	function automatic logic [srfr_pkg::LEVEL_W-1:0] floor_root(input longint unsigned v);
		longint unsigned root;
		longint unsigned cand;
		root = 0;
		for (int b = srfr_pkg::LEVEL_W; b >= 0; b--) begin
			cand = root | (64'd1 << b);
			if (cand * cand <= v)
				root = cand;
		end
		return root[srfr_pkg::LEVEL_W-1:0];
	endfunction

	function automatic srfr_pkg::out_item_t make_result(input logic [1:0] kind,
			input logic signed [srfr_pkg::SMP_W-1:0] smp, input logic last);
		srfr_pkg::out_item_t r;
		r.result_kind     = kind;
		r.sample_out      = smp;
		r.frame_last      = last;
		r.available_count = ring_fill();
		r.rms_level       = level_now;
		return r;
	endfunction

	task automatic predict_ring_results(input srfr_pkg::in_item_t it);
		logic signed [srfr_pkg::SMP_W-1:0] frame_buf [FRAME_LEN];
		longint sv;
		if (it.opcode == srfr_pkg::OP_PUSH) begin
			if (!capture_on) begin
				pending_results.push_back(make_result(srfr_pkg::KIND_DROP, '0, 1'b0));
			end else begin
				ring_mem[wr_ptr] = it.sample_in;
				wr_ptr = wr_ptr + 1'b1;
				if (wr_ptr == rd_ptr)
					rd_ptr = rd_ptr + 1'b1;
				sv = it.sample_in;
				sq_acc = sq_acc + longint'(sv * sv);
				blk_cnt = blk_cnt + 1;
				if (it.block_end || blk_cnt >= BLOCK_LIMIT) begin
					level_now = floor_root(sq_acc / blk_cnt);
					sq_acc = 0;
					blk_cnt = 0;
				end
				pending_results.push_back(make_result(srfr_pkg::KIND_STORED, '0, 1'b0));
			end
		end else if (ring_fill() < FRAME_LEN) begin
			pending_results.push_back(make_result(srfr_pkg::KIND_NA, '0, 1'b0));
		end else begin
			for (int i = 0; i < FRAME_LEN; i++)
				frame_buf[i] = ring_mem[rd_ptr + srfr_pkg::AVAIL_W'(i)];
			rd_ptr = rd_ptr + srfr_pkg::AVAIL_W'(FRAME_LEN);
			for (int i = 0; i < FRAME_LEN; i++)
				pending_results.push_back(make_result(srfr_pkg::KIND_FRAME, frame_buf[i],
					i == FRAME_LEN - 1));
		end
	endtask

	function automatic logic signed [srfr_pkg::SMP_W-1:0] pick_sample();
		logic [31:0] r;
		r = $urandom;
		case (r[18:16])
			3'd0: return 16'sh8000;
			3'd1: return 16'sh7FFF;
			3'd2: return 16'sd0;
			3'd3: return -16'sd1;
			default: return r[15:0];
		endcase
	endfunction

	function automatic srfr_pkg::in_item_t make_item(input int read_pct, input int bend_pct);
		srfr_pkg::in_item_t it;
		it.opcode    = ($urandom_range(0, 99) < read_pct) ? srfr_pkg::OP_READ
		                                                  : srfr_pkg::OP_PUSH;
		it.sample_in = pick_sample();
		it.block_end = ($urandom_range(0, 99) < bend_pct);
		return it;
	endfunction

	task automatic note_failure(input string what, input srfr_pkg::out_item_t want,
			input srfr_pkg::out_item_t got);
		err_count++;
		if (err_count <= 10) begin
			$display("%0t %0s: expected kind=%0d sample=%0d last=%0d avail=%0d level=%0d",
				$time, what, want.result_kind, want.sample_out, want.frame_last,
				want.available_count, want.rms_level);
			$display("    got kind=%0d sample=%0d last=%0d avail=%0d level=%0d",
				got.result_kind, got.sample_out, got.frame_last,
				got.available_count, got.rms_level);
		end
	endtask

	task automatic drive_item(input srfr_pkg::in_item_t it, input int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= it;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predict_ring_results(it);
	endtask

	task automatic settle_results();
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic set_capture(input logic en);
		settle_results();
		repeat (8) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= en;
		@(posedge clk);
		cfg_we <= 1'b0;
		capture_on = en;
	endtask

	task automatic run_phase(input int n, input int idle_pct, input int stall_pct,
			input int read_pct, input int bend_pct);
		sink_stall_pct = stall_pct;
		repeat (n) drive_item(make_item(read_pct, bend_pct), idle_pct);
		settle_results();
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_done != hold_asked) begin
			rsp_stall <= 1'b1;
			hold_left <= HOLD_LEN;
			hold_done <= hold_done + 1;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		srfr_pkg::out_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_results.size() == 0) begin
				note_failure("unexpected transaction", '0, rsp_data);
			end else begin
				want = pending_results.pop_front();
				if (rsp_data.result_kind !== want.result_kind ||
						rsp_data.sample_out !== want.sample_out ||
						rsp_data.frame_last !== want.frame_last ||
						rsp_data.available_count !== want.available_count ||
						rsp_data.rms_level !== want.rms_level)
					note_failure("mismatch", want, rsp_data);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		dir_row_t            row;
		srfr_pkg::in_item_t  it;
		srfr_pkg::out_item_t typed_exp;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.act == ROW_CFG) begin
				set_capture(row.flag);
			end else begin
				it.opcode    = (row.act == ROW_READ) ? srfr_pkg::OP_READ : srfr_pkg::OP_PUSH;
				it.sample_in = row.smp;
				it.block_end = row.flag;
				drive_item(it, 0);
				if (row.typed) begin
					typed_exp                 = '0;
					typed_exp.result_kind     = row.kind;
					typed_exp.available_count = row.avail;
					typed_exp.rms_level       = row.lvl;
					void'(pending_results.pop_back());
					pending_results.push_back(typed_exp);
				end
			end
		end

		run_phase(60, 0, 0, 8, 15);
		run_phase(60, 73, 0, 8, 15);
		run_phase(60, 0, 73, 8, 15);
		run_phase(60, 19, 19, 8, 15);
		run_phase(30, 0, 0, 0, 10);
		set_capture(1'b0);
		run_phase(40, 19, 19, 30, 15);
		set_capture(1'b1);
		hold_asked++;
		run_phase(40, 0, 0, 15, 15);

		// top up the ring, then drain it in whole frames
		sink_stall_pct = 0;
		repeat (FILL_PUSHES) drive_item(make_item(0, 0), 0);
		settle_results();
		sink_stall_pct = 19;
		while (ring_fill() >= FRAME_LEN)
			drive_item(make_item(100, 50), 0);
		drive_item(make_item(100, 50), 0);
		settle_results();

		repeat (SETTLE) @(posedge clk);
		if (err_count == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
